FILE: hdl/scc_pkg.sv
// shared types and constants for the stripe column centroid core
// no dependencies; imported by every module of the block
package scc_pkg;

  localparam int PIX_W       = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 8;

  // result field widths, fixed by the output beat format
  localparam int OUT_COL_W   = 12;
  localparam int OUT_CTR_W   = 19;
  localparam int OUT_LEN_W   = 12;
  localparam int OUT_BEG_W   = 11;
  localparam int OUT_END_W   = 12;
  localparam int OUT_TDATA_W = 72;

  // bit offsets inside out_tdata
  localparam int OFS_COL = 0;
  localparam int OFS_CTR = OFS_COL + OUT_COL_W;
  localparam int OFS_LEN = OFS_CTR + OUT_CTR_W;
  localparam int OFS_BEG = OFS_LEN + OUT_LEN_W;
  localparam int OFS_END = OFS_BEG + OUT_BEG_W;
  localparam int OFS_PAD = OFS_END + OUT_END_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE      = 1'b1;

  localparam logic MODE_ALL = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  localparam logic [PIX_W-1:0] THRESHOLD_RST = '0;
  localparam logic             MODE_RST      = MODE_RUN;

  // accumulator commands
  typedef struct packed {
    logic step;
    logic close;
    logic clear;
  } acc_cmd_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: hdl/scc_acc.sv
// per-column accumulator: row counter, current and widest run, totals
// depends on scc_pkg
module scc_acc #(
  parameter int MAX_ROWS = 2048,
  parameter int ROW_W    = 12,
  parameter int RIDX_W   = 11,
  parameter int WGT_W    = 19,
  parameter int MOM_W    = 30
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  scc_pkg::acc_cmd_t        cmd,
  input  logic [scc_pkg::PIX_W-1:0] pix,
  input  logic [scc_pkg::PIX_W-1:0] thr,
  output logic [ROW_W-1:0]         best_len,
  output logic [RIDX_W-1:0]        best_start,
  output logic [ROW_W-1:0]         best_end,
  output logic [WGT_W-1:0]         best_wgt,
  output logic [MOM_W-1:0]         best_mom,
  output logic [WGT_W-1:0]         tot_wgt,
  output logic [MOM_W-1:0]         tot_mom
);
  import scc_pkg::*;

  localparam int PROD_W = RIDX_W + PIX_W;

  logic [ROW_W-1:0]  row_r,       row_nxt;
  logic [ROW_W-1:0]  cur_len_r,   cur_len_nxt;
  logic [RIDX_W-1:0] cur_start_r, cur_start_nxt;
  logic [WGT_W-1:0]  cur_wgt_r,   cur_wgt_nxt;
  logic [MOM_W-1:0]  cur_mom_r,   cur_mom_nxt;
  logic [ROW_W-1:0]  best_len_r,  best_len_nxt;
  logic [RIDX_W-1:0] best_start_r, best_start_nxt;
  logic [ROW_W-1:0]  best_end_r,  best_end_nxt;
  logic [WGT_W-1:0]  best_wgt_r,  best_wgt_nxt;
  logic [MOM_W-1:0]  best_mom_r,  best_mom_nxt;
  logic [WGT_W-1:0]  tot_wgt_r,   tot_wgt_nxt;
  logic [MOM_W-1:0]  tot_mom_r,   tot_mom_nxt;

  logic                    in_range;
  logic                    stripe;
  logic                    take;
  logic [RIDX_W-1:0]       row_idx;
  logic [PROD_W-1:0]       prod;
  logic [MOM_W+PROD_W-1:0] prod_ext;
  logic [MOM_W-1:0]        prod_m;
  logic [WGT_W-1:0]        pix_w;

  assign in_range = row_r < ROW_W'(MAX_ROWS);
  assign stripe   = pix > thr;
  assign take     = cur_len_r > best_len_r;
  assign row_idx  = row_r[RIDX_W-1:0];
  assign prod     = PROD_W'(row_idx) * PROD_W'(pix);
  assign prod_ext = {{MOM_W{1'b0}}, prod};
  assign prod_m   = prod_ext[MOM_W-1:0];
  assign pix_w    = WGT_W'(pix);

  always_comb begin
    row_nxt        = row_r;
    cur_len_nxt    = cur_len_r;
    cur_start_nxt  = cur_start_r;
    cur_wgt_nxt    = cur_wgt_r;
    cur_mom_nxt    = cur_mom_r;
    best_len_nxt   = best_len_r;
    best_start_nxt = best_start_r;
    best_end_nxt   = best_end_r;
    best_wgt_nxt   = best_wgt_r;
    best_mom_nxt   = best_mom_r;
    tot_wgt_nxt    = tot_wgt_r;
    tot_mom_nxt    = tot_mom_r;
    if (cmd.clear) begin
      row_nxt        = '0;
      cur_len_nxt    = '0;
      cur_start_nxt  = '0;
      cur_wgt_nxt    = '0;
      cur_mom_nxt    = '0;
      best_len_nxt   = '0;
      best_start_nxt = '0;
      best_end_nxt   = '0;
      best_wgt_nxt   = '0;
      best_mom_nxt   = '0;
      tot_wgt_nxt    = '0;
      tot_mom_nxt    = '0;
    end else if (cmd.close || (cmd.step && in_range && !stripe)) begin
      // run ends: keep it if strictly wider than the best so far
      if (take) begin
        best_len_nxt   = cur_len_r;
        best_start_nxt = cur_start_r;
        best_end_nxt   = ROW_W'(cur_start_r) + cur_len_r;
        best_wgt_nxt   = cur_wgt_r;
        best_mom_nxt   = cur_mom_r;
      end
      cur_len_nxt = '0;
      cur_wgt_nxt = '0;
      cur_mom_nxt = '0;
      if (cmd.step) begin
        row_nxt = row_r + 1'b1;
      end
    end else if (cmd.step && in_range) begin
      if (cur_len_r == '0) begin
        cur_start_nxt = row_idx;
        cur_wgt_nxt   = pix_w;
        cur_mom_nxt   = prod_m;
      end else begin
        cur_wgt_nxt = cur_wgt_r + pix_w;
        cur_mom_nxt = cur_mom_r + prod_m;
      end
      cur_len_nxt = cur_len_r + 1'b1;
      tot_wgt_nxt = tot_wgt_r + pix_w;
      tot_mom_nxt = tot_mom_r + prod_m;
      row_nxt     = row_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r        <= '0;
      cur_len_r    <= '0;
      cur_start_r  <= '0;
      cur_wgt_r    <= '0;
      cur_mom_r    <= '0;
      best_len_r   <= '0;
      best_start_r <= '0;
      best_end_r   <= '0;
      best_wgt_r   <= '0;
      best_mom_r   <= '0;
      tot_wgt_r    <= '0;
      tot_mom_r    <= '0;
    end else begin
      row_r        <= row_nxt;
      cur_len_r    <= cur_len_nxt;
      cur_start_r  <= cur_start_nxt;
      cur_wgt_r    <= cur_wgt_nxt;
      cur_mom_r    <= cur_mom_nxt;
      best_len_r   <= best_len_nxt;
      best_start_r <= best_start_nxt;
      best_end_r   <= best_end_nxt;
      best_wgt_r   <= best_wgt_nxt;
      best_mom_r   <= best_mom_nxt;
      tot_wgt_r    <= tot_wgt_nxt;
      tot_mom_r    <= tot_mom_nxt;
    end
  end

  assign best_len   = best_len_r;
  assign best_start = best_start_r;
  assign best_end   = best_end_r;
  assign best_wgt   = best_wgt_r;
  assign best_mom   = best_mom_r;
  assign tot_wgt    = tot_wgt_r;
  assign tot_mom    = tot_mom_r;

endmodule

FILE: hdl/scc_div.sv
// restoring divider, one quotient bit per cycle through a shared subtractor
// depends on scc_pkg; quotient must fit in QUO_W bits
module scc_div #(
  parameter int DVD_W = 38,
  parameter int WGT_W = 19,
  parameter int QUO_W = 19
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DVD_W-1:0]   dividend,
  input  logic [WGT_W-1:0]   divisor,
  output scc_pkg::div_stat_t stat,
  output logic [QUO_W-1:0]   quotient
);
  import scc_pkg::*;

  localparam int CNT_W = $clog2(QUO_W + 1);

  logic [WGT_W-1:0] rem_r, rem_nxt;
  logic [WGT_W-1:0] dsr_r, dsr_nxt;
  logic [QUO_W-1:0] sh_r,  sh_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;

  logic [DVD_W+WGT_W-1:0] hi_ext;
  logic [WGT_W:0]         trial;
  logic                   ge;
  logic [WGT_W:0]         diff;
  logic [QUO_W:0]         sh_shift;

  // upper dividend bits are below the divisor when the quotient fits
  assign hi_ext   = {{WGT_W{1'b0}}, dividend >> QUO_W};
  assign trial    = {rem_r, sh_r[QUO_W-1]};
  assign ge       = trial >= {1'b0, dsr_r};
  assign diff     = trial - {1'b0, dsr_r};
  assign sh_shift = {sh_r, ge};

  always_comb begin
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    if (start) begin
      rem_nxt  = hi_ext[WGT_W-1:0];
      dsr_nxt  = divisor;
      sh_nxt   = dividend[QUO_W-1:0];
      cnt_nxt  = CNT_W'(QUO_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[WGT_W-1:0] : trial[WGT_W-1:0];
      sh_nxt   = sh_shift[QUO_W-1:0];
      cnt_nxt  = cnt_r - 1'b1;
      busy_nxt = cnt_r != CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    sh_r  <= sh_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = busy_r && (cnt_r == CNT_W'(1));
  assign quotient  = sh_r;

endmodule

FILE: hdl/stripe_column_centroid_core.sv
// top level of the laser stripe column centroid core
// depends on scc_pkg, scc_acc and scc_div
// usage
//   input beats carry one pixel each, in row order down one column
//   (in_tdata = gray value, in_tlast = last pixel of the column,
//   in_tuser = first pixel of a frame, which restarts column numbering)
//   one output beat per column, made after the beat with in_tlast;
//   registers (threshold, mode) are written through cfg_* by the user
//   while no column result is pending; the block does not enforce it
// rate: while a column is open a pixel is taken every cycle
//   after the last pixel in_tready stays low while the core closes the open
//   run, chooses weight and moment, runs QUO_W steps of the shared subtractor
//   and loads the output register once it is free; the subtractor steps are
//   skipped when no stripe pixel was seen
// stalls
//   a finished beat waits in the output register while out_tready is low;
//   the next column is still taken, the one after waits for the drain
// reset
//   rst_n (synchronous) clears all counters and sums, threshold to 0,
//   mode to widest-run centroid, and drops out_tvalid
module stripe_column_centroid_core #(
  parameter int MAX_ROWS  = 2048,
  parameter int MAX_COLS  = 4096,
  parameter int FRAC_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // pixel stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [scc_pkg::IN_TDATA_W-1:0]    in_tdata,  // [7:0] pixel_value
  input  logic                              in_tlast,  // last_in_column
  input  logic                              in_tuser,  // [0] frame_start
  // column results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [11:0] column_number, [30:12] center_row_fixed, [42:31] run_width,
  // [53:43] run_begin, [65:54] run_finish, [71:66] zero
  output logic [scc_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tuser, // [0] found
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [scc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [scc_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import scc_pkg::*;

  // sizes that follow from the row and column limits
  localparam int ROW_W  = $clog2(MAX_ROWS + 1);
  localparam int RIDX_W = $clog2(MAX_ROWS);
  localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam longint unsigned WGT_MAX = 64'd255 * MAX_ROWS;
  localparam longint unsigned MOM_MAX = 64'd255 * MAX_ROWS * (MAX_ROWS - 1) / 2;
  localparam int WGT_W  = $clog2(WGT_MAX + 1);
  localparam int MOM_W  = $clog2(MOM_MAX + 1);
  localparam int DVD_W  = MOM_W + FRAC_BITS;
  // centre never exceeds the last row, so this many quotient bits suffice
  localparam int QUO_W  = RIDX_W + FRAC_BITS;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CLOSE = 5'b00010,
    ST_START = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [PIX_W-1:0] thr_r;
  logic             mode_r;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             found_r;

  logic                   out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic                   out_found_r;

  logic in_beat;
  logic out_free;
  logic load_out;

  acc_cmd_t  acc_cmd;
  div_stat_t div_stat;
  logic      div_start;

  logic [ROW_W-1:0]  best_len;
  logic [RIDX_W-1:0] best_start;
  logic [ROW_W-1:0]  best_end;
  logic [WGT_W-1:0]  best_wgt;
  logic [MOM_W-1:0]  best_mom;
  logic [WGT_W-1:0]  tot_wgt;
  logic [MOM_W-1:0]  tot_mom;

  logic [WGT_W-1:0] sel_wgt;
  logic [MOM_W-1:0] sel_mom;
  logic             found_now;
  logic [DVD_W-1:0] dividend;
  logic [QUO_W-1:0] quotient;

  // field resizing to the fixed beat layout
  logic [COL_W+OUT_COL_W-1:0]  col_ext;
  logic [QUO_W+OUT_CTR_W-1:0]  ctr_ext;
  logic [ROW_W+OUT_LEN_W-1:0]  len_ext;
  logic [RIDX_W+OUT_BEG_W-1:0] beg_ext;
  logic [ROW_W+OUT_END_W-1:0]  end_ext;
  logic [OUT_TDATA_W-1:0]      beat_data;

  assign in_tready = state_r == ST_IDLE;
  assign in_beat   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_tready;
  assign load_out  = (state_r == ST_DONE) && out_free;

  // registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= THRESHOLD_RST;
      mode_r <= MODE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_THRESHOLD: thr_r  <= cfg_data[PIX_W-1:0];
        CFG_MODE:      mode_r <= cfg_data[0];
      endcase
    end
  end

  // accumulator commands come straight from the sequencer
  assign acc_cmd.step  = in_beat;
  assign acc_cmd.close = state_r == ST_CLOSE;
  assign acc_cmd.clear = load_out;

  scc_acc #(
    .MAX_ROWS (MAX_ROWS),
    .ROW_W    (ROW_W),
    .RIDX_W   (RIDX_W),
    .WGT_W    (WGT_W),
    .MOM_W    (MOM_W)
  ) u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (acc_cmd),
    .pix        (in_tdata[PIX_W-1:0]),
    .thr        (thr_r),
    .best_len   (best_len),
    .best_start (best_start),
    .best_end   (best_end),
    .best_wgt   (best_wgt),
    .best_mom   (best_mom),
    .tot_wgt    (tot_wgt),
    .tot_mom    (tot_mom)
  );

  // weight and moment of all stripe pixels or of the widest run
  assign sel_wgt   = (mode_r == MODE_ALL) ? tot_wgt : best_wgt;
  assign sel_mom   = (mode_r == MODE_ALL) ? tot_mom : best_mom;
  assign found_now = (best_len != '0) && (sel_wgt != '0);
  assign dividend  = DVD_W'(sel_mom) << FRAC_BITS;
  assign div_start = (state_r == ST_START) && found_now;

  scc_div #(
    .DVD_W (DVD_W),
    .WGT_W (WGT_W),
    .QUO_W (QUO_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (sel_wgt),
    .stat     (div_stat),
    .quotient (quotient)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_beat && in_tlast) state_nxt = ST_CLOSE;
      ST_CLOSE: state_nxt = ST_START;
      ST_START: state_nxt = found_now ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_stat.done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // column number: frame start clears it before the pixel is used,
  // each emitted column advances it with wrap
  always_comb begin
    col_nxt = col_r;
    if (in_beat && in_tuser) begin
      col_nxt = '0;
    end else if (load_out) begin
      col_nxt = (col_r == COL_W'(MAX_COLS - 1)) ? '0 : col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      col_r   <= '0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      if (state_r == ST_START) begin
        found_r <= found_now;
      end
    end
  end

  assign col_ext = {{OUT_COL_W{1'b0}}, col_r};
  assign ctr_ext = {{OUT_CTR_W{1'b0}}, quotient};
  assign len_ext = {{OUT_LEN_W{1'b0}}, best_len};
  assign beg_ext = {{OUT_BEG_W{1'b0}}, best_start};
  assign end_ext = {{OUT_END_W{1'b0}}, best_end};

  // not found: every field but the column number reads zero
  always_comb begin
    beat_data = '0;
    beat_data[OFS_COL +: OUT_COL_W] = col_ext[OUT_COL_W-1:0];
    if (found_r) begin
      beat_data[OFS_CTR +: OUT_CTR_W] = ctr_ext[OUT_CTR_W-1:0];
      beat_data[OFS_LEN +: OUT_LEN_W] = len_ext[OUT_LEN_W-1:0];
      beat_data[OFS_BEG +: OUT_BEG_W] = beg_ext[OUT_BEG_W-1:0];
      beat_data[OFS_END +: OUT_END_W] = end_ext[OUT_END_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_data_r  <= beat_data;
      out_found_r <= found_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_found_r;

endmodule

FILE: hdl/scc_checker.sv
// port-level checks for the stripe column centroid core, bound to the top
// depends on scc_pkg and stripe_column_centroid_core
module scc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            in_tlast,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [scc_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import scc_pkg::*;

  // the last pixel of a column always blocks the input for the result
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input still ready after last pixel of a column");

  // a result only appears when the input was blocked in the cycle before
  a_result_after_block: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("result beat appeared without input being blocked");

  // no stripe: centre and run fields are zero
  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[OUT_TDATA_W-1:OFS_CTR] == '0)
    else $error("non-zero result fields on a column with no stripe");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser))
    else $error("result beat changed while stalled");

endmodule

bind stripe_column_centroid_core scc_checker u_scc_checker (.*);

FILE: tb/stripe_column_centroid_core_test.sv
`timescale 1ns / 1ps
// self-checking testbench for the stripe column centroid core: a directed table, then random
// columns under changing idling, with every result beat checked against a typed or predicted result
// depends on scc_pkg and stripe_column_centroid_core
module stripe_column_centroid_core_test;
  import scc_pkg::*;

  localparam int MAX_ROWS      = 2048;
  localparam int MAX_COLS      = 4096;
  localparam int FRAC_BITS     = 8;
  // settle time after the last expected result, covering any work still in flight
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SEG_PIXELS    = 160;
  localparam int TAIL_COLUMNS  = 200;
  localparam int DIR_ROWS      = 32;

  // one column result as it leaves the block
  typedef struct packed {
    logic                 found;
    logic [OUT_COL_W-1:0] col;
    logic [OUT_CTR_W-1:0] ctr;
    logic [OUT_LEN_W-1:0] wid;
    logic [OUT_BEG_W-1:0] beg;
    logic [OUT_END_W-1:0] fin;
  } col_result_t;

  // a pixel beat, a register write, or a whole column of one value
  typedef enum logic [1:0] {ROW_PIX, ROW_CFG, ROW_FILL} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [PIX_W-1:0]      pix;
    logic                  last;
    logic                  fs;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    logic [15:0]           len;
    logic                  chk;   // res below is the typed expectation
    col_result_t           res;
  } stim_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   in_tlast   = 1'b0;
  logic                   in_tuser   = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  stripe_column_centroid_core #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS),
    .FRAC_BITS(FRAC_BITS)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // directed table, fields in order: kind, pixel, last, frame start, reg index, reg data,
  // fill length, typed flag, typed result {found, column, centre, width, begin, end}
  stim_row_t dir_tbl [DIR_ROWS] = '{
    // straight after reset: threshold 0, widest-run mode, zero is not stripe
    '{ROW_PIX, 8'd0, 1'b1, 1'b1, CFG_THRESHOLD, 8'd0, 16'd0, 1'b1,
      '{1'b0, 12'd0, 19'd0, 12'd0, 11'd0, 12'd0}},
    // brightest pixel alone at row 0
    '{ROW_PIX, 8'd255, 1'b1, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b1,
      '{1'b1, 12'd1, 19'd0, 12'd1, 11'd0, 12'd1}},
    '{ROW_PIX, 8'd0, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd255, 1'b1, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b1,
      '{1'b1, 12'd2, 19'd256, 12'd1, 11'd1, 12'd2}},
    // two runs, the wider second one still open at the column end
    '{ROW_PIX, 8'd10, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd10, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd0, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd20, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd20, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd20, 1'b1, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    // equally wide runs: the first one wins
    '{ROW_PIX, 8'd50, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd0, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd50, 1'b1, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b1,
      '{1'b1, 12'd4, 19'd0, 12'd1, 11'd0, 12'd1}},
    // centroid over all stripe pixels, run fields still give the widest run
    '{ROW_CFG, 8'd0, 1'b0, 1'b0, CFG_MODE, {7'd0, MODE_ALL}, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd100, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd0, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd100, 1'b1, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    // top threshold: nothing can be stripe
    '{ROW_CFG, 8'd0, 1'b0, 1'b0, CFG_THRESHOLD, 8'd255, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd255, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd255, 1'b1, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b1,
      '{1'b0, 12'd6, 19'd0, 12'd0, 11'd0, 12'd0}},
    '{ROW_CFG, 8'd0, 1'b0, 1'b0, CFG_THRESHOLD, 8'd128, 16'd0, 1'b0, '0},
    '{ROW_CFG, 8'd0, 1'b0, 1'b0, CFG_MODE, {7'd0, MODE_RUN}, 16'd0, 1'b0, '0},
    // frame start on the last pixel itself
    '{ROW_PIX, 8'd200, 1'b1, 1'b1, CFG_THRESHOLD, 8'd0, 16'd0, 1'b1,
      '{1'b1, 12'd0, 19'd0, 12'd1, 11'd0, 12'd1}},
    // threshold moved in mid-column, just above and at its edge
    '{ROW_PIX, 8'd129, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd128, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_CFG, 8'd0, 1'b0, 1'b0, CFG_THRESHOLD, 8'd250, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd200, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd251, 1'b1, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    // mode changed in mid-column, taken when the result is formed
    '{ROW_PIX, 8'd251, 1'b0, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    '{ROW_CFG, 8'd0, 1'b0, 1'b0, CFG_MODE, {7'd0, MODE_ALL}, 16'd0, 1'b0, '0},
    '{ROW_PIX, 8'd251, 1'b1, 1'b0, CFG_THRESHOLD, 8'd0, 16'd0, 1'b0, '0},
    // tall column of the brightest value: one run from the top row down
    '{ROW_FILL, 8'd255, 1'b1, 1'b0, CFG_THRESHOLD, 8'd0, 16'd100, 1'b0, '0}
  };

  // predictor copy of the registers and the column state
  logic [PIX_W-1:0]  thr_reg;
  logic              mode_reg;
  int                rows_seen;
  int                col_idx;
  logic [11:0]       run_len;
  logic [10:0]       run_start;
  logic [18:0]       run_wt;
  logic [29:0]       run_mom;
  logic [11:0]       wide_len;
  logic [10:0]       wide_start;
  logic [11:0]       wide_end;
  logic [18:0]       wide_wt;
  logic [29:0]       wide_mom;
  logic [18:0]       sum_wt;
  logic [29:0]       sum_mom;

  col_result_t       pending_centres [$];
  col_result_t       beat_seen;
  col_result_t       beat_want;
  int                mismatch_cnt  = 0;
  int                cycle_cnt     = 0;
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                hold_left     = 0;
  bit                hold_req      = 1'b0;

  function automatic void clear_column();
    rows_seen  = 0;
    run_len    = '0;
    run_start  = '0;
    run_wt     = '0;
    run_mom    = '0;
    wide_len   = '0;
    wide_start = '0;
    wide_end   = '0;
    wide_wt    = '0;
    wide_mom   = '0;
    sum_wt     = '0;
    sum_mom    = '0;
  endfunction

  // a broken run replaces the widest one only when strictly wider
  function automatic void end_run();
    if (run_len > wide_len) begin
      wide_len   = run_len;
      wide_start = run_start;
      wide_end   = 12'(run_start) + run_len;
      wide_wt    = run_wt;
      wide_mom   = run_mom;
    end
    run_len = '0;
    run_wt  = '0;
    run_mom = '0;
  endfunction

  // advances the column state by one pixel; returns 1 with the column result on its last pixel
  function automatic bit centroid_step(input logic [PIX_W-1:0] pix, input logic last,
                                       input logic fs, output col_result_t res);
    logic [10:0] r;
    logic [18:0] wt;
    logic [29:0] mom;
    logic [63:0] num;
    logic        hit;
    res = '0;
    if (fs) col_idx = 0;
    if (rows_seen < MAX_ROWS) begin
      r = rows_seen[10:0];
      if (pix > thr_reg) begin
        if (run_len == 0) begin
          run_start = r;
          run_wt    = '0;
          run_mom   = '0;
        end
        run_len = run_len + 12'd1;
        run_wt  = run_wt + 19'(pix);
        run_mom = run_mom + 30'(r) * 30'(pix);
        sum_wt  = sum_wt + 19'(pix);
        sum_mom = sum_mom + 30'(r) * 30'(pix);
      end else begin
        end_run();
      end
      rows_seen++;
    end
    if (!last) return 1'b0;
    end_run();
    if (mode_reg == MODE_ALL) begin
      wt  = sum_wt;
      mom = sum_mom;
    end else begin
      wt  = wide_wt;
      mom = wide_mom;
    end
    hit = (wide_len != 0) && (wt != 0);
    if (hit) begin
      num     = 64'(mom) << FRAC_BITS;
      res.ctr = OUT_CTR_W'(num / 64'(wt));
      res.wid = wide_len;
      res.beg = wide_start;
      res.fin = wide_end;
    end
    res.found = hit;
    res.col   = col_idx[OUT_COL_W-1:0];
    col_idx   = (col_idx + 1 >= MAX_COLS) ? 0 : col_idx + 1;
    clear_column();
    return 1'b1;
  endfunction

  // one pixel beat, preceded by random idle cycles; when use_typed is set, the typed result replaces the predicted one
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic last, input logic fs,
                            input col_result_t typed, input logic use_typed);
    col_result_t res;
    bit          got;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = pix;
    in_tlast  = last;
    in_tuser  = fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    got = centroid_step(pix, last, fs, res);
    if (got) pending_centres = {pending_centres, (use_typed ? typed : res)};
    @(negedge clk);
  endtask

  // sender pauses until every expected result is out and the block has gone quiet
  task automatic drain();
    in_tvalid = 1'b0;
    while (pending_centres.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    drain();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_THRESHOLD) thr_reg = val;
    else mode_reg = val[0];
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // random column: stripe-like runs on a dark background, some pure noise, rare frame starts
  task automatic send_column(input int len);
    int   v;
    bit   in_stripe;
    logic fs;
    in_stripe = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (in_stripe) in_stripe = ($urandom_range(99) >= 30);
      else in_stripe = ($urandom_range(99) < 15);
      if ($urandom_range(99) < 10 || (in_stripe && thr_reg == 8'd255))
        v = $urandom_range(255, 0);
      else if (in_stripe)
        v = $urandom_range(255, int'(thr_reg) + 1);
      else
        v = $urandom_range(int'(thr_reg), 0);
      fs = (i == 0) ? ($urandom_range(99) < 5) : ($urandom_range(199) == 0);
      send_pixel(v[PIX_W-1:0], i == len - 1, fs, '0, 1'b0);
    end
  endtask

  // receiver: random hold-off, or a long stall when asked for
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready = 1'b0;
      hold_left--;
    end else begin
      out_tready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // result checker, oldest expectation first
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beat_seen.found = out_tuser;
      beat_seen.col   = out_tdata[OFS_COL +: OUT_COL_W];
      beat_seen.ctr   = out_tdata[OFS_CTR +: OUT_CTR_W];
      beat_seen.wid   = out_tdata[OFS_LEN +: OUT_LEN_W];
      beat_seen.beg   = out_tdata[OFS_BEG +: OUT_BEG_W];
      beat_seen.fin   = out_tdata[OFS_END +: OUT_END_W];
      if (pending_centres.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("unexpected beat: found %0d col %0d centre %0d width %0d begin %0d end %0d",
                   beat_seen.found, beat_seen.col, beat_seen.ctr, beat_seen.wid,
                   beat_seen.beg, beat_seen.fin);
      end else begin
        beat_want = pending_centres.pop_front();
        if (beat_seen !== beat_want) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("result mismatch (expected/actual): found %0d/%0d col %0d/%0d",
                     beat_want.found, beat_seen.found, beat_want.col, beat_seen.col);
            $display("  centre %0d/%0d width %0d/%0d begin %0d/%0d end %0d/%0d",
                     beat_want.ctr, beat_seen.ctr, beat_want.wid, beat_seen.wid,
                     beat_want.beg, beat_seen.beg, beat_want.fin, beat_seen.fin);
          end
        end
      end
    end
  end

  // run-away guard
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int         seg_pix;
    int         col_len;
    logic [7:0] seg_thr;
    thr_reg  = THRESHOLD_RST;
    mode_reg = MODE_RST;
    col_idx  = 0;
    clear_column();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part under the first idling setting
    send_idle_pct = 30;
    recv_idle_pct = 48;
    for (int k = 0; k < DIR_ROWS; k++) begin
      unique case (dir_tbl[k].kind)
        ROW_PIX: begin
          send_pixel(dir_tbl[k].pix, dir_tbl[k].last, dir_tbl[k].fs, dir_tbl[k].res,
                     dir_tbl[k].chk);
        end
        ROW_CFG: begin
          write_reg(dir_tbl[k].idx, dir_tbl[k].val);
        end
        default: begin
          for (int j = 0; j < int'(dir_tbl[k].len); j++)
            send_pixel(dir_tbl[k].pix, j == int'(dir_tbl[k].len) - 1, 1'b0, dir_tbl[k].res,
                       dir_tbl[k].chk);
        end
      endcase
    end

    // random segments: two per idling setting, fresh registers for each
    for (int s = 0; s < 6; s++) begin
      unique case (s / 2)
        0: begin
          send_idle_pct = 30;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 30;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      unique case (s)
        0: seg_thr = 8'd0;
        2: seg_thr = 8'd254;
        4: seg_thr = 8'd1;
        default: seg_thr = 8'($urandom_range(255, 0));
      endcase
      write_reg(CFG_THRESHOLD, seg_thr);
      write_reg(CFG_MODE, {7'd0, (s % 3 == 1) ? MODE_ALL : MODE_RUN});
      if (s == 1) begin
        // long receiver stall while pixels keep coming, so the block backs up
        @(posedge clk);
        hold_req = 1'b1;
        @(negedge clk);
      end
      seg_pix = 0;
      while (seg_pix < SEG_PIXELS) begin
        if ($urandom_range(99) < 85) col_len = $urandom_range(24, 1);
        else col_len = $urandom_range(200, 25);
        send_column(col_len);
        seg_pix += (col_len < MAX_ROWS) ? col_len : MAX_ROWS;
      end
    end

    // single-pixel columns with no frame start, back to back
    write_reg(CFG_THRESHOLD, 8'($urandom_range(255, 0)));
    write_reg(CFG_MODE, {7'd0, 1'($urandom_range(1, 0))});
    for (int c = 0; c < TAIL_COLUMNS; c++)
      send_pixel(8'($urandom_range(255, 0)), 1'b1, 1'b0, '0, 1'b0);

    drain();
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
